[sv/lca_pkg.sv]
package lca_pkg;

  localparam int COST_W   = 24;
  localparam int WGT_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int RTT_W    = 16;
  localparam int LOSS_W   = 17;
  localparam int TMO_W    = 8;
  localparam int SECS_W   = 16;
  localparam int NIDX_W   = 4;

  localparam int RBAND_W  = 10;
  localparam int VBAND_W  = 9;
  localparam int SBAND_W  = 16;
  localparam int ADJ_W    = 28;
  localparam int FAC_W    = 28;
  localparam int RAW_W    = 23;
  localparam int RES_W    = 35;

  localparam logic [CFG_IDX_W-1:0] CFG_RTT_WEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAB_WEIGHT = 2'd2;

  localparam logic [WGT_W-1:0] WGT_RESET = 12'd256;

  localparam logic [RTT_W-1:0] RTT_LIM_0 = 16'd10;
  localparam logic [RTT_W-1:0] RTT_LIM_1 = 16'd50;
  localparam logic [RTT_W-1:0] RTT_LIM_2 = 16'd100;
  localparam logic [RTT_W-1:0] RTT_LIM_3 = 16'd200;

  localparam logic [RBAND_W-1:0] RBAND_0 = 10'd0;
  localparam logic [RBAND_W-1:0] RBAND_1 = 10'd51;
  localparam logic [RBAND_W-1:0] RBAND_2 = 10'd128;
  localparam logic [RBAND_W-1:0] RBAND_3 = 10'd256;
  localparam logic [RBAND_W-1:0] RBAND_4 = 10'd512;

  localparam logic [VBAND_W-1:0] VBAND_0 = 9'd0;
  localparam logic [VBAND_W-1:0] VBAND_1 = 9'd76;
  localparam logic [VBAND_W-1:0] VBAND_2 = 9'd179;
  localparam logic [VBAND_W-1:0] VBAND_3 = 9'd384;

  localparam int VAR_MIN_SAMPLES = 3;

  localparam logic [SECS_W-1:0] STALE_SECS     = 16'd60;
  localparam logic [SECS_W-1:0] STALE_SAT_SECS = 16'd1203;
  localparam logic [9:0]        STALE_MAX      = 10'd512;
  localparam logic [9:0]        LOSS_MAX_BAND  = 10'd512;
  localparam logic [15:0]       STALE_RECIP    = 16'd55925;
  localparam int                STALE_SHIFT    = 22;

  localparam logic [FAC_W-1:0]  ONE_Q16  = 28'd65536;
  localparam logic [COST_W-1:0] COST_MAX = 24'd8388607;

endpackage

[sv/lca_ram.sv]
module lca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/link_cost_adjuster.sv]
// Link cost adjuster.
// Input: a report is transferred at a rising edge with start high and busy low.
// It names a neighbor, a signed Q15.8 base cost and link health data.
// Output: out_valid is high for exactly one cycle with out_adjusted_cost; the
// receiver takes it at the edge that ends that cycle and cannot stall it.
// Config: cfg_valid/cfg_ready write channel, cfg_ready always high; index 0..2
// selects the RTT, load and stability weights (Q4.8); other indexes are dropped.
// Write weights only while busy is low and no result is pending.
// Sequencing: a base cost of zero or less returns unchanged through the S_PASS
// state. Otherwise one shared multiplier is visited in sequence for the RTT
// squares, the window variance terms, the staleness reciprocal, the three
// weights and the final scale, plus the S_OLD state for the window memory
// read when the RTT is valid.
// Throughput: busy is high from the transfer until the result cycle, so a new
// report may be transferred in the same cycle the result is shown.
// Reset (synchronous, rst_n low): weights return to 1.0, every neighbor's
// sample count, slot and running sums are cleared; the window memory is not.
module link_cost_adjuster #(
  parameter int NEIGHBORS = 16,
  parameter int WINDOW    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lca_pkg::NIDX_W-1:0]           in_neighbor_index,
  input  logic signed [lca_pkg::COST_W-1:0]    in_base_cost,
  input  logic                                 in_rtt_valid,
  input  logic [lca_pkg::RTT_W-1:0]            in_rtt_ms,
  input  logic [lca_pkg::LOSS_W-1:0]           in_loss_rate,
  input  logic [lca_pkg::TMO_W-1:0]            in_timeout_count,
  input  logic [lca_pkg::SECS_W-1:0]           in_seconds_since_success,
  output logic                                 out_valid,
  output logic signed [lca_pkg::COST_W-1:0]    out_adjusted_cost,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lca_pkg::WGT_W-1:0]            cfg_data
);

  localparam int NB_W   = NEIGHBORS > 1 ? $clog2(NEIGHBORS) : 1;
  localparam int DEPTH  = NEIGHBORS * WINDOW;
  localparam int AW     = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int SL_W   = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * 65535 + 1);
  localparam longint unsigned SQ_MAX = longint'(WINDOW) * 64'd4294836225;
  localparam int SQ_W   = $clog2(SQ_MAX + 1);
  localparam int SS_W   = 2 * SUM_W;
  localparam int NQ_W   = SQ_W + CNT_W;
  localparam int DW     = NQ_W > SS_W ? NQ_W : SS_W;
  localparam int CMP_W  = DW + 7;
  localparam int MA     = SQ_W > lca_pkg::FAC_W ? SQ_W : lca_pkg::FAC_W;
  localparam int MB     = SUM_W > lca_pkg::RAW_W ? SUM_W : lca_pkg::RAW_W;
  localparam int MP     = MA + MB;
  localparam int RTT_SQ_W = 2 * lca_pkg::RTT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_LOAD, S_OLD, S_SS, S_NQ, S_V0, S_V1, S_V2,
    S_ST, S_W0, S_W1, S_W2, S_RES, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic                             out_valid_r;
  logic [lca_pkg::COST_W-1:0]       out_cost_r;
  logic [lca_pkg::WGT_W-1:0]        w_rtt_r, w_load_r, w_stab_r;

  logic [CNT_W-1:0]                 cnt_tab_r [NEIGHBORS];
  logic [SL_W-1:0]                  slot_tab_r [NEIGHBORS];
  logic [SUM_W-1:0]                 sum_tab_r [NEIGHBORS];
  logic [SQ_W-1:0]                  sq_tab_r [NEIGHBORS];

  logic [NB_W-1:0]                  n_r;
  logic [lca_pkg::COST_W-1:0]       raw_r;
  logic                             valid_r;
  logic [lca_pkg::RTT_W-1:0]        rtt_r;
  logic [lca_pkg::LOSS_W-1:0]       loss_r;
  logic [lca_pkg::TMO_W-1:0]        tmo_r;
  logic [lca_pkg::SECS_W-1:0]       secs_r;

  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [SL_W-1:0]                  slot_r, slot_nxt;
  logic [SUM_W-1:0]                 sum_r, sum_nxt;
  logic [SQ_W-1:0]                  sq_r, sq_nxt;
  logic [RTT_SQ_W-1:0]              p_r;
  logic [SS_W-1:0]                  ss_r;
  logic [DW-1:0]                    d_r, d_nxt;
  logic [lca_pkg::RBAND_W-1:0]      rband_r, rband_nxt;
  logic [lca_pkg::VBAND_W-1:0]      vband_r;
  logic [lca_pkg::SBAND_W-1:0]      sband_r, sband_nxt;
  logic [lca_pkg::ADJ_W-1:0]        adj_r;
  logic [lca_pkg::RES_W-1:0]        res_r;
  logic [lca_pkg::COST_W-1:0]       cost_nxt;

  logic [MA-1:0]                    mul_a;
  logic [MB-1:0]                    mul_b;
  logic [MP-1:0]                    mul_p;

  logic [NB_W-1:0]                  nmod [16];
  logic                             accept;
  logic                             nonpos;
  logic                             full;
  logic [lca_pkg::RTT_W-1:0]        old_rtt;
  logic [AW-1:0]                    rd_addr, wr_addr;
  logic                             ram_we;
  logic [CMP_W-1:0]                 d25, lhs;
  logic                             var_le, var_skip;
  logic [9:0]                       stale, loss_band;

  for (genvar gi = 0; gi < 16; gi++) begin : g_nmod
    assign nmod[gi] = NB_W'(gi % NEIGHBORS);
  end

  assign accept    = start && (state_r == S_IDLE);
  assign nonpos    = in_base_cost[lca_pkg::COST_W-1] || (in_base_cost == '0);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_adjusted_cost = out_cost_r;

  assign rd_addr = AW'(int'(n_r) * WINDOW + int'(slot_tab_r[n_r]));
  assign wr_addr = AW'(int'(n_r) * WINDOW + int'(slot_r));
  assign ram_we  = (state_r == S_OLD);

  lca_ram #(
    .WIDTH(lca_pkg::RTT_W),
    .DEPTH(DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(rtt_r),
    .raddr(rd_addr),
    .rdata(old_rtt)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LOAD: begin
        mul_a = MA'(rtt_r);
        mul_b = MB'(rtt_r);
      end
      S_OLD: begin
        mul_a = MA'(old_rtt);
        mul_b = MB'(old_rtt);
      end
      S_SS: begin
        mul_a = MA'(sum_r);
        mul_b = MB'(sum_r);
      end
      S_NQ: begin
        mul_a = MA'(sq_r);
        mul_b = MB'(cnt_r);
      end
      S_ST: begin
        mul_a = MA'({secs_r[10:0], 5'b0});
        mul_b = MB'(lca_pkg::STALE_RECIP);
      end
      S_W0: begin
        mul_a = MA'(rband_r);
        mul_b = MB'(w_rtt_r);
      end
      S_W1: begin
        mul_a = MA'(vband_r);
        mul_b = MB'(w_load_r);
      end
      S_W2: begin
        mul_a = MA'(sband_r);
        mul_b = MB'(w_stab_r);
      end
      S_RES: begin
        mul_a = MA'(lca_pkg::ONE_Q16 + adj_r);
        mul_b = MB'(raw_r[lca_pkg::RAW_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MP'(mul_a) * MP'(mul_b);

  always_comb begin
    if (rtt_r <= lca_pkg::RTT_LIM_0)      rband_nxt = lca_pkg::RBAND_0;
    else if (rtt_r <= lca_pkg::RTT_LIM_1) rband_nxt = lca_pkg::RBAND_1;
    else if (rtt_r <= lca_pkg::RTT_LIM_2) rband_nxt = lca_pkg::RBAND_2;
    else if (rtt_r <= lca_pkg::RTT_LIM_3) rband_nxt = lca_pkg::RBAND_3;
    else                                  rband_nxt = lca_pkg::RBAND_4;
    if (!valid_r) rband_nxt = lca_pkg::RBAND_0;
  end

  assign full     = (cnt_r >= CNT_W'(WINDOW));
  assign slot_nxt = (slot_r == SL_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
  assign cnt_nxt  = full ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    if (full) begin
      sum_nxt = sum_r - SUM_W'(old_rtt) + SUM_W'(rtt_r);
      sq_nxt  = sq_r - SQ_W'(mul_p[RTT_SQ_W-1:0]) + SQ_W'(p_r);
    end else begin
      sum_nxt = sum_r + SUM_W'(rtt_r);
      sq_nxt  = sq_r + SQ_W'(p_r);
    end
  end

  always_comb begin
    if (DW'(mul_p[NQ_W-1:0]) > DW'(ss_r)) d_nxt = DW'(mul_p[NQ_W-1:0]) - DW'(ss_r);
    else                                   d_nxt = '0;
  end

  assign d25 = (CMP_W'(d_r) << 4) + (CMP_W'(d_r) << 3) + CMP_W'(d_r);

  always_comb begin
    case (state_r)
      S_V0:    lhs = d25 << 2;
      S_V1:    lhs = d25;
      default: lhs = CMP_W'(d_r) << 2;
    endcase
  end

  assign var_le   = (lhs <= CMP_W'(ss_r));
  assign var_skip = (cnt_r < CNT_W'(lca_pkg::VAR_MIN_SAMPLES)) || (sum_r == '0);

  always_comb begin
    if (secs_r <= lca_pkg::STALE_SECS)          stale = '0;
    else if (secs_r >= lca_pkg::STALE_SAT_SECS) stale = lca_pkg::STALE_MAX;
    else stale = mul_p[lca_pkg::STALE_SHIFT+9:lca_pkg::STALE_SHIFT];
    loss_band = loss_r[16] ? lca_pkg::LOSS_MAX_BAND : 10'(loss_r[15:7]);
    sband_nxt = lca_pkg::SBAND_W'(loss_band) + lca_pkg::SBAND_W'({tmo_r, 7'b0})
              + lca_pkg::SBAND_W'(stale);
  end

  always_comb begin
    logic [lca_pkg::RES_W-1:0] hi, lo, r;
    hi = lca_pkg::RES_W'(raw_r) + lca_pkg::RES_W'({raw_r, 1'b0});
    lo = lca_pkg::RES_W'(raw_r >> 1);
    r  = res_r;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    if (r > lca_pkg::RES_W'(lca_pkg::COST_MAX)) r = lca_pkg::RES_W'(lca_pkg::COST_MAX);
    cost_nxt = r[lca_pkg::COST_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = nonpos ? S_PASS : S_LOAD;
      S_PASS:  state_nxt = S_IDLE;
      S_LOAD:  state_nxt = valid_r ? S_OLD : S_SS;
      S_OLD:   state_nxt = S_SS;
      S_SS:    state_nxt = S_NQ;
      S_NQ:    state_nxt = S_V0;
      S_V0:    state_nxt = (var_skip || var_le) ? S_ST : S_V1;
      S_V1:    state_nxt = var_le ? S_ST : S_V2;
      S_V2:    state_nxt = S_ST;
      S_ST:    state_nxt = S_W0;
      S_W0:    state_nxt = S_W1;
      S_W1:    state_nxt = S_W2;
      S_W2:    state_nxt = S_RES;
      S_RES:   state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      w_rtt_r     <= lca_pkg::WGT_RESET;
      w_load_r    <= lca_pkg::WGT_RESET;
      w_stab_r    <= lca_pkg::WGT_RESET;
      for (int i = 0; i < NEIGHBORS; i++) begin
        cnt_tab_r[i]  <= '0;
        slot_tab_r[i] <= '0;
        sum_tab_r[i]  <= '0;
        sq_tab_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_PASS) || (state_r == S_FIN);
      if (state_r == S_PASS) out_cost_r <= raw_r;
      if (state_r == S_FIN)  out_cost_r <= cost_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lca_pkg::CFG_RTT_WEIGHT:  w_rtt_r  <= cfg_data;
          lca_pkg::CFG_LOAD_WEIGHT: w_load_r <= cfg_data;
          lca_pkg::CFG_STAB_WEIGHT: w_stab_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_OLD) begin
        cnt_tab_r[n_r]  <= cnt_nxt;
        slot_tab_r[n_r] <= slot_nxt;
        sum_tab_r[n_r]  <= sum_nxt;
        sq_tab_r[n_r]   <= sq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          n_r     <= nmod[in_neighbor_index];
          raw_r   <= in_base_cost;
          valid_r <= in_rtt_valid;
          rtt_r   <= in_rtt_ms;
          loss_r  <= in_loss_rate;
          tmo_r   <= in_timeout_count;
          secs_r  <= in_seconds_since_success;
        end
      end
      S_LOAD: begin
        cnt_r   <= cnt_tab_r[n_r];
        slot_r  <= slot_tab_r[n_r];
        sum_r   <= sum_tab_r[n_r];
        sq_r    <= sq_tab_r[n_r];
        p_r     <= mul_p[RTT_SQ_W-1:0];
        rband_r <= rband_nxt;
      end
      S_OLD: begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        sq_r  <= sq_nxt;
      end
      S_SS:  ss_r <= mul_p[SS_W-1:0];
      S_NQ:  d_r  <= d_nxt;
      S_V0:  vband_r <= lca_pkg::VBAND_0;
      S_V1:  vband_r <= var_le ? lca_pkg::VBAND_1 : lca_pkg::VBAND_0;
      S_V2:  vband_r <= var_le ? lca_pkg::VBAND_2 : lca_pkg::VBAND_3;
      S_ST:  sband_r <= sband_nxt;
      S_W0:  adj_r <= mul_p[lca_pkg::ADJ_W-1:0];
      S_W1:  adj_r <= adj_r + mul_p[lca_pkg::ADJ_W-1:0];
      S_W2:  adj_r <= adj_r + mul_p[lca_pkg::ADJ_W-1:0];
      S_RES: res_r <= mul_p[lca_pkg::RES_W+15:16];
      default: ;
    endcase
  end

endmodule

[sv/lca_checker.sv]
module lca_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic [lca_pkg::NIDX_W-1:0]           in_neighbor_index,
  input logic signed [lca_pkg::COST_W-1:0]    in_base_cost,
  input logic                                 in_rtt_valid,
  input logic [lca_pkg::RTT_W-1:0]            in_rtt_ms,
  input logic [lca_pkg::LOSS_W-1:0]           in_loss_rate,
  input logic [lca_pkg::TMO_W-1:0]            in_timeout_count,
  input logic [lca_pkg::SECS_W-1:0]           in_seconds_since_success,
  input logic                                 out_valid,
  input logic signed [lca_pkg::COST_W-1:0]    out_adjusted_cost,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [lca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic [lca_pkg::WGT_W-1:0]            cfg_data
);

  logic xfer;
  logic base_nonpos;

  assign xfer        = start && !busy;
  assign base_nonpos = in_base_cost[lca_pkg::COST_W-1] || (in_base_cost == '0);

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> busy)
    else $error("busy not raised after transfer");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in flight");

  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && base_nonpos) |=> ##1
      (out_valid && (out_adjusted_cost == $past(in_base_cost, 2))))
    else $error("nonpositive base cost not passed through");

endmodule

bind link_cost_adjuster lca_checker u_lca_checker (.*);
